@@ sv/all_pairs_shortest_path_core_assert.svh @@
// Assertion macros for the shortest-path core.
`ifndef ALL_PAIRS_SHORTEST_PATH_CORE_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define APSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("apsp assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define APSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("apsp assertion failed");

`endif

@@ sv/apsp_pkg.sv @@
// Shared types and constants for the shortest-path core.
package apsp_pkg;

  localparam int PRED_W = 5;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_INFINITY     = 1'b1;

  localparam logic [4:0]  VCOUNT_RESET = 5'd16;
  localparam logic [30:0] INF_RESET    = 31'd10000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_IK,
    ST_GET_IK,
    ST_RD_KJ,
    ST_RD_IJ,
    ST_UPD,
    ST_DONE
  } state_t;

endpackage

@@ sv/all_pairs_shortest_path_core.sv @@
// Top level of the all-pairs shortest-path core (Floyd-Warshall with predecessors).
//
// Usage:
//   Issue a word by raising start while busy is low; in_kind selects the job.
//   A weight write (in_row, in_col, in_weight) returns nothing.
//   A read returns distance, predecessor and unreachable on the out_ ports with
//   out_valid high for one cycle; the data passes through the RAM read register and
//   the result register. Reads and writes may be issued every cycle while busy is low.
//   A run holds busy high while it relaxes the matrix and then strobes one result
//   with out_run_done set. Every matrix read goes through the single read port
//   of the distance/predecessor RAM; each relaxation step reads (k,j), reads (i,j)
//   and may then write (i,j); a row with an infinite pivot entry is skipped entirely.
//   The user must write vertex_count and infinity_value on the cfg_ port only
//   while the core is idle; the core itself does not enforce this.
// Reset sets both registers to their defaults and clears the sequencer; the
// matrix is not cleared and holds garbage until written. Results cannot be held
// off: the receiver must take each word in its strobe cycle.
`include "all_pairs_shortest_path_core_assert.svh"

module all_pairs_shortest_path_core #(
  parameter int MAX_VERTICES = 16,
  parameter int DIST_WIDTH   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic [3:0]         in_row,
  input  logic [3:0]         in_col,
  input  logic signed [31:0] in_weight,
  output logic               out_valid,
  output logic signed [31:0] out_distance,
  output logic [4:0]         out_predecessor,
  output logic               out_unreachable,
  output logic               out_run_done,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_data
);

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = apsp_pkg::PRED_W;
  localparam int EW    = DIST_WIDTH + PW;
  localparam int CW    = ((DIST_WIDTH > 32) ? DIST_WIDTH : 32) + 1;

  localparam logic signed [CW-1:0] DMAX_C =
    {{(CW - DIST_WIDTH + 1){1'b0}}, {(DIST_WIDTH - 1){1'b1}}};
  localparam logic signed [CW-1:0] DMIN_C = ~DMAX_C;
  localparam logic signed [CW-1:0] OMAX_C = {{(CW - 31){1'b0}}, {31{1'b1}}};
  localparam logic signed [CW-1:0] OMIN_C = ~OMAX_C;

  function automatic logic [AW-1:0] cell_addr(input logic [VW-1:0] r,
                                               input logic [VW-1:0] c);
    return AW'(32'(r) * MAX_VERTICES + 32'(c));
  endfunction

  // configuration
  logic [4:0]  vcount_r;
  logic [30:0] inf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= apsp_pkg::VCOUNT_RESET;
      inf_r    <= apsp_pkg::INF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        apsp_pkg::CFG_VERTEX_COUNT: vcount_r <= cfg_data[4:0];
        apsp_pkg::CFG_INFINITY:     inf_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [CW-1:0] inf_ext;
  assign inf_ext = signed'({{(CW - 31){1'b0}}, inf_r});

  // matrix RAM, entry = {predecessor, distance}
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  apsp_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_matrix (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  logic signed [DIST_WIDTH-1:0] rd_dist;
  logic [PW-1:0]                rd_pred;
  logic signed [CW-1:0]         rd_ext;
  logic                         rd_ge_inf;

  assign rd_dist   = signed'(ram_rdata[DIST_WIDTH-1:0]);
  assign rd_pred   = ram_rdata[EW-1:DIST_WIDTH];
  assign rd_ext    = CW'(rd_dist);
  assign rd_ge_inf = (rd_ext >= inf_ext);

  // host side decode
  logic          in_range;
  logic [AW-1:0] in_addr;
  logic          accept;

  assign in_range = (32'(in_row) < MAX_VERTICES) && (32'(in_col) < MAX_VERTICES);
  assign in_addr  = AW'(32'(in_row) * MAX_VERTICES + 32'(in_col));
  assign accept   = start && !busy;

  // weight write: saturate into the stored width
  logic signed [CW-1:0]         w_ext;
  logic signed [CW-1:0]         w_sat;
  logic signed [DIST_WIDTH-1:0] wr_dist;
  logic [PW-1:0]                wr_pred;

  always_comb begin
    w_ext = {{(CW - 32){in_weight[31]}}, in_weight};
    if (w_ext > DMAX_C) begin
      w_sat = DMAX_C;
    end else if (w_ext < DMIN_C) begin
      w_sat = DMIN_C;
    end else begin
      w_sat = w_ext;
    end
    wr_dist = w_sat[DIST_WIDTH-1:0];
    wr_pred = ((in_row != in_col) && (w_sat < inf_ext)) ? PW'(in_row) + 1'b1 : '0;
  end

  // run sequencer state
  apsp_pkg::state_t state_r, state_nxt;
  logic [VW-1:0] i_r, i_nxt;
  logic [VW-1:0] j_r, j_nxt;
  logic [VW-1:0] k_r, k_nxt;
  logic [VW-1:0] last_r, last_nxt;
  logic signed [DIST_WIDTH-1:0] dik_r, dik_nxt;
  logic signed [DIST_WIDTH-1:0] dkj_r, dkj_nxt;
  logic [PW-1:0] pkj_r, pkj_nxt;
  logic rd_pend_r, rd_pend_nxt;
  logic rd_oor_r, rd_oor_nxt;

  logic [VW-1:0] run_last;
  assign run_last = (32'(vcount_r) > MAX_VERTICES) ? VW'(MAX_VERTICES - 1)
                                                   : VW'(32'(vcount_r) - 1);

  // relaxation compare
  logic signed [CW-1:0]         sum_ext;
  logic signed [CW-1:0]         sum_sat;
  logic                         shorter;
  logic signed [DIST_WIDTH-1:0] new_dist;

  always_comb begin
    sum_ext  = CW'(dik_r) + CW'(dkj_r);
    shorter  = (sum_ext < rd_ext);
    sum_sat  = (sum_ext < DMIN_C) ? DMIN_C : sum_ext;
    new_dist = sum_sat[DIST_WIDTH-1:0];
  end

  // where the walk goes after the last column of a row
  apsp_pkg::state_t row_state;
  logic [VW-1:0]    row_i;
  logic [VW-1:0]    row_k;

  always_comb begin
    row_state = apsp_pkg::ST_RD_IK;
    row_i     = i_r;
    row_k     = k_r;
    if (i_r != last_r) begin
      row_i = VW'(i_r + 1'b1);
    end else if (k_r != last_r) begin
      row_i = '0;
      row_k = VW'(k_r + 1'b1);
    end else begin
      row_state = apsp_pkg::ST_DONE;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    last_nxt    = last_r;
    dik_nxt     = dik_r;
    dkj_nxt     = dkj_r;
    pkj_nxt     = pkj_r;
    rd_pend_nxt = 1'b0;
    rd_oor_nxt  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = in_addr;
    ram_wdata   = {wr_pred, wr_dist};
    ram_raddr   = in_addr;
    case (state_r)
      apsp_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            apsp_pkg::KIND_WRITE: ram_we = in_range;
            apsp_pkg::KIND_RUN: begin
              last_nxt  = run_last;
              i_nxt     = '0;
              j_nxt     = '0;
              k_nxt     = '0;
              state_nxt = (vcount_r == '0) ? apsp_pkg::ST_DONE : apsp_pkg::ST_RD_IK;
            end
            apsp_pkg::KIND_READ: begin
              rd_pend_nxt = 1'b1;
              rd_oor_nxt  = !in_range;
            end
            default: ;
          endcase
        end
      end
      apsp_pkg::ST_RD_IK: begin
        ram_raddr = cell_addr(i_r, k_r);
        state_nxt = apsp_pkg::ST_GET_IK;
      end
      apsp_pkg::ST_GET_IK: begin
        dik_nxt = rd_dist;
        // infinite pivot entry: drop the whole row
        if (rd_ge_inf) begin
          state_nxt = row_state;
          i_nxt     = row_i;
          k_nxt     = row_k;
        end else begin
          j_nxt     = '0;
          state_nxt = apsp_pkg::ST_RD_KJ;
        end
      end
      apsp_pkg::ST_RD_KJ: begin
        ram_raddr = cell_addr(k_r, j_r);
        state_nxt = apsp_pkg::ST_RD_IJ;
      end
      apsp_pkg::ST_RD_IJ: begin
        dkj_nxt   = rd_dist;
        pkj_nxt   = rd_pred;
        ram_raddr = cell_addr(i_r, j_r);
        if (!rd_ge_inf) begin
          state_nxt = apsp_pkg::ST_UPD;
        end else if (j_r != last_r) begin
          j_nxt     = VW'(j_r + 1'b1);
          state_nxt = apsp_pkg::ST_RD_KJ;
        end else begin
          state_nxt = row_state;
          i_nxt     = row_i;
          k_nxt     = row_k;
        end
      end
      apsp_pkg::ST_UPD: begin
        ram_waddr = cell_addr(i_r, j_r);
        ram_wdata = {pkj_r, new_dist};
        ram_we    = shorter;
        if (j_r != last_r) begin
          j_nxt     = VW'(j_r + 1'b1);
          state_nxt = apsp_pkg::ST_RD_KJ;
        end else begin
          state_nxt = row_state;
          i_nxt     = row_i;
          k_nxt     = row_k;
        end
      end
      apsp_pkg::ST_DONE: state_nxt = apsp_pkg::ST_IDLE;
      default: state_nxt = apsp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= apsp_pkg::ST_IDLE;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    last_r   <= last_nxt;
    dik_r    <= dik_nxt;
    dkj_r    <= dkj_nxt;
    pkj_r    <= pkj_nxt;
    rd_oor_r <= rd_oor_nxt;
  end

  assign busy = (state_r != apsp_pkg::ST_IDLE);

  // result word
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_dist_r, out_dist_nxt;
  logic [4:0]         out_pred_r, out_pred_nxt;
  logic               out_unr_r, out_unr_nxt;
  logic               out_done_r, out_done_nxt;
  logic signed [CW-1:0] rd_clamp;

  always_comb begin
    if (rd_ext > OMAX_C) begin
      rd_clamp = OMAX_C;
    end else if (rd_ext < OMIN_C) begin
      rd_clamp = OMIN_C;
    end else begin
      rd_clamp = rd_ext;
    end
    out_valid_nxt = 1'b0;
    out_dist_nxt  = '0;
    out_pred_nxt  = '0;
    out_unr_nxt   = 1'b0;
    out_done_nxt  = 1'b0;
    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
      if (!rd_oor_r) begin
        out_dist_nxt = rd_clamp[31:0];
        out_pred_nxt = 5'(rd_pred);
        out_unr_nxt  = (rd_ext == inf_ext);
      end
    end else if (state_r == apsp_pkg::ST_DONE) begin
      out_valid_nxt = 1'b1;
      out_done_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dist_r <= out_dist_nxt;
    out_pred_r <= out_pred_nxt;
    out_unr_r  <= out_unr_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_distance    = out_dist_r;
  assign out_predecessor = out_pred_r;
  assign out_unreachable = out_unr_r;
  assign out_run_done    = out_done_r;

  `APSP_ASSERT_NOW(a_done_from_seq, out_valid && out_run_done, $past(state_r) == apsp_pkg::ST_DONE)
  `APSP_ASSERT_NEXT(a_run_holds_busy, accept && (in_kind == apsp_pkg::KIND_RUN), busy)
  `APSP_ASSERT_NOW(a_run_write_slot, busy && ram_we, state_r == apsp_pkg::ST_UPD)
  `APSP_ASSERT_NOW(a_idx_bound, busy && (state_r != apsp_pkg::ST_DONE), (i_r <= last_r) && (j_r <= last_r) && (k_r <= last_r))

endmodule

@@ sv/apsp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module apsp_ram #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the all-pairs shortest-path core.
module testbench;

  localparam int         N_MAX        = 16;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         RESULT_DELAY = 2;
  localparam int         STALL_LIMIT  = 65000;
  localparam int         WORD_TARGET  = 430;
  localparam longint     DIST_MIN     = -(longint'(1) <<< 31);

  typedef struct packed {
    logic signed [31:0] distance;
    logic [4:0]         predecessor;
    logic               unreachable;
    logic               run_done;
  } path_result_t;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  logic               busy;
  logic [1:0]         in_kind   = '0;
  logic [3:0]         in_row    = '0;
  logic [3:0]         in_col    = '0;
  logic signed [31:0] in_weight = '0;
  logic               out_valid;
  logic signed [31:0] out_distance;
  logic [4:0]         out_predecessor;
  logic               out_unreachable;
  logic               out_run_done;
  logic               cfg_we    = 1'b0;
  logic               cfg_index = 1'b0;
  logic [30:0]        cfg_data  = '0;

  // Shadow copy of the matrices and registers
  longint       distance_mirror [N_MAX*N_MAX];
  logic [4:0]   pred_mirror     [N_MAX*N_MAX];
  bit           cell_loaded     [N_MAX*N_MAX];
  logic [4:0]   vcount_mirror = apsp_pkg::VCOUNT_RESET;
  logic [30:0]  inf_mirror    = apsp_pkg::INF_RESET;

  path_result_t pending_results [$];
  int           mismatch_count = 0;
  int           sent_words     = 0;
  int           max_gap        = 3;
  int           stall_cycles   = 0;

  all_pairs_shortest_path_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_weight       (in_weight),
    .out_valid       (out_valid),
    .out_distance    (out_distance),
    .out_predecessor (out_predecessor),
    .out_unreachable (out_unreachable),
    .out_run_done    (out_run_done),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void relax_matrix();
    int     n;
    longint inf;
    longint dik;
    longint dkj;
    longint sum;
    n   = (vcount_mirror > 5'd16) ? N_MAX : int'(vcount_mirror);
    inf = longint'(inf_mirror);
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < n; i++) begin
        // pivot entry is taken once per row, even if the row changes it
        dik = distance_mirror[i*N_MAX + k];
        if (dik >= inf) continue;
        for (int j = 0; j < n; j++) begin
          dkj = distance_mirror[k*N_MAX + j];
          if (dkj >= inf) continue;
          sum = dik + dkj;
          if (sum < distance_mirror[i*N_MAX + j]) begin
            distance_mirror[i*N_MAX + j] = (sum < DIST_MIN) ? DIST_MIN : sum;
            pred_mirror[i*N_MAX + j]     = pred_mirror[k*N_MAX + j];
          end
        end
      end
    end
  endfunction

  function automatic void predict_word(input logic [1:0] kind, input logic [3:0] row,
                                       input logic [3:0] col, input logic signed [31:0] weight);
    int           idx;
    longint       wide;
    path_result_t res;
    idx = int'({row, col});
    res = '0;
    case (kind)
      apsp_pkg::KIND_WRITE: begin
        wide                 = longint'(weight);
        distance_mirror[idx] = wide;
        pred_mirror[idx]     = (row != col && wide < longint'(inf_mirror)) ?
                               {1'b0, row} + 5'd1 : 5'd0;
        cell_loaded[idx]     = 1'b1;
      end
      apsp_pkg::KIND_RUN: begin
        relax_matrix();
        res.run_done = 1'b1;
        pending_results.push_back(res);
      end
      apsp_pkg::KIND_READ: begin
        res.distance    = 32'(distance_mirror[idx]);
        res.predecessor = pred_mirror[idx];
        res.unreachable = (distance_mirror[idx] == longint'(inf_mirror));
        pending_results.push_back(res);
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input logic [1:0] kind, input logic [3:0] row,
                           input logic [3:0] col, input logic signed [31:0] weight);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_kind   <= kind;
    in_row    <= row;
    in_col    <= col;
    in_weight <= weight;
    do @(posedge clk); while (busy);
    predict_word(kind, row, col, weight);
    if (kind != KIND_UNUSED) sent_words++;
  endtask

  // Drain all pending results, then let any trailing write settle
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (RESULT_DELAY + 2) @(posedge clk);
  endtask

  task automatic set_register(input logic idx, input logic [30:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == apsp_pkg::CFG_VERTEX_COUNT) vcount_mirror = value[4:0];
    else inf_mirror = value;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_weight();
    case ($urandom_range(0, 15))
      0, 1, 2, 3: return {1'b0, inf_mirror};
      4:          return $urandom;
      5:          return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      6:          return -(int'($urandom_range(1, 50)));
      default:    return $urandom_range(0, 60);
    endcase
  endfunction

  task automatic read_random_cell(input int span);
    logic [3:0] r;
    logic [3:0] c;
    do begin
      r = 4'($urandom_range(0, span - 1));
      c = 4'($urandom_range(0, span - 1));
    end while (!cell_loaded[int'({r, c})]);
    send_word(apsp_pkg::KIND_READ, r, c, $urandom);
  endtask

  task automatic send_noise();
    send_word(KIND_UNUSED, 4'($urandom), 4'($urandom), $urandom);
  endtask

  // Fill the top-left n x n block with a random graph, with reads and noise mixed in
  task automatic load_block(input int n);
    logic signed [31:0] w;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        w = (i == j && $urandom_range(0, 3) != 0) ? 32'sd0 : pick_weight();
        send_word(apsp_pkg::KIND_WRITE, 4'(i), 4'(j), w);
        if ($urandom_range(0, 7) == 0) read_random_cell(N_MAX);
        if ($urandom_range(0, 15) == 0) send_noise();
      end
    end
  endtask

  task automatic run_and_read(input int reads, input int span);
    send_word(apsp_pkg::KIND_RUN, 4'($urandom), 4'($urandom), $urandom);
    repeat (reads) read_random_cell(span);
  endtask

  task automatic test_single_cells();
    send_word(apsp_pkg::KIND_WRITE, 4'd0, 4'd0, 32'sd0);
    send_word(apsp_pkg::KIND_READ, 4'd0, 4'd0, 32'sd0);
    send_word(apsp_pkg::KIND_WRITE, 4'd0, 4'd15, 32'sh7FFFFFFF);
    send_word(apsp_pkg::KIND_READ, 4'd0, 4'd15, 32'sd0);
    send_word(apsp_pkg::KIND_WRITE, 4'd15, 4'd0, 32'sh80000000);
    send_word(apsp_pkg::KIND_READ, 4'd15, 4'd0, 32'shFFFFFFFF);
    send_word(apsp_pkg::KIND_WRITE, 4'd3, 4'd5, 32'sd10000000);
    send_word(apsp_pkg::KIND_READ, 4'd3, 4'd5, 32'sd0);
    send_word(apsp_pkg::KIND_WRITE, 4'd5, 4'd3, 32'sd9999999);
    send_word(apsp_pkg::KIND_READ, 4'd5, 4'd3, 32'sd0);
    send_word(apsp_pkg::KIND_WRITE, 4'd15, 4'd15, -32'sd1);
    send_word(apsp_pkg::KIND_READ, 4'd15, 4'd15, 32'sd0);
    // unused kind must leave the entry alone
    send_word(KIND_UNUSED, 4'd3, 4'd5, 32'sd7);
    send_word(apsp_pkg::KIND_READ, 4'd3, 4'd5, 32'sd0);
    send_word(apsp_pkg::KIND_WRITE, 4'd10, 4'd6, 32'sd0);
    send_word(apsp_pkg::KIND_READ, 4'd10, 4'd6, 32'sd0);
    send_word(apsp_pkg::KIND_WRITE, 4'd10, 4'd6, 32'sd42);
    send_word(apsp_pkg::KIND_READ, 4'd10, 4'd6, 32'sd0);
  endtask

  task automatic test_default_closure();
    load_block(N_MAX);
    run_and_read(20, N_MAX);
  endtask

  task automatic test_empty_run();
    wait_quiet();
    set_register(apsp_pkg::CFG_VERTEX_COUNT, 31'd0);
    run_and_read(6, N_MAX);
  endtask

  task automatic test_oversized_count();
    wait_quiet();
    set_register(apsp_pkg::CFG_VERTEX_COUNT, 31'h7FFFFFFF);
    max_gap = 0;
    repeat (10) send_word(apsp_pkg::KIND_WRITE, 4'($urandom), 4'($urandom), pick_weight());
    run_and_read(20, N_MAX);
    max_gap = 3;
  endtask

  task automatic test_infinity_extremes();
    wait_quiet();
    set_register(apsp_pkg::CFG_INFINITY, 31'd0);
    set_register(apsp_pkg::CFG_VERTEX_COUNT, 31'd16);
    repeat (12) send_word(apsp_pkg::KIND_WRITE, 4'($urandom), 4'($urandom),
                          -(int'($urandom_range(1, 1000))));
    send_word(apsp_pkg::KIND_WRITE, 4'd2, 4'd7, 32'sh80000000);
    run_and_read(10, N_MAX);
    wait_quiet();
    set_register(apsp_pkg::CFG_INFINITY, 31'h7FFFFFFF);
    repeat (8) send_word(apsp_pkg::KIND_WRITE, 4'($urandom), 4'($urandom), 32'sh7FFFFFFF);
    repeat (8) send_word(apsp_pkg::KIND_WRITE, 4'($urandom), 4'($urandom),
                         $urandom_range(0, 500));
    run_and_read(10, N_MAX);
  endtask

  task automatic test_random_closures();
    int          n;
    int          big_runs;
    logic [30:0] inf_pick;
    big_runs = 0;
    while (sent_words < WORD_TARGET) begin
      wait_quiet();
      if (big_runs < 2 && $urandom_range(0, 9) == 0) begin
        n = N_MAX;
        big_runs++;
      end else begin
        n = $urandom_range(1, 6);
      end
      case ($urandom_range(0, 4))
        0:       inf_pick = 31'($urandom_range(5, 60));
        1:       inf_pick = apsp_pkg::INF_RESET;
        2:       inf_pick = 31'($urandom);
        3:       inf_pick = 31'h7FFFFFFF;
        default: inf_pick = 31'($urandom_range(0, 100));
      endcase
      set_register(apsp_pkg::CFG_INFINITY, inf_pick);
      set_register(apsp_pkg::CFG_VERTEX_COUNT, {26'($urandom), 5'(n)});
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : 3;
      // big runs reuse the matrix; small ones mostly reload their block
      if (n == N_MAX) begin
        repeat (10) send_word(apsp_pkg::KIND_WRITE, 4'($urandom), 4'($urandom),
                              pick_weight());
      end else if ($urandom_range(0, 4) != 0) begin
        load_block(n);
      end
      run_and_read(2 * n + 2, n);
      if ($urandom_range(0, 3) == 0) run_and_read(n, n);
    end
    max_gap = 3;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_single_cells();
    test_default_closure();
    test_empty_run();
    test_oversized_count();
    test_infinity_extremes();
    test_random_closures();
    wait_quiet();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[all_pairs_shortest_path_core] OK");
    end else begin
      $display("[all_pairs_shortest_path_core] ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin : check_results
    path_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: dist %0d pred %0d unreachable %0b done %0b",
                   out_distance, out_predecessor, out_unreachable, out_run_done);
      end else begin
        want = pending_results.pop_front();
        if (out_distance !== want.distance || out_predecessor !== want.predecessor ||
            out_unreachable !== want.unreachable || out_run_done !== want.run_done) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected dist %0d pred %0d unreachable %0b done %0b, got dist %0d pred %0d unreachable %0b done %0b",
                     want.distance, want.predecessor, want.unreachable, want.run_done,
                     out_distance, out_predecessor, out_unreachable, out_run_done);
        end
      end
    end
  end

  // Abort when no word moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[all_pairs_shortest_path_core] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/apsp_pkg.sv
sv/apsp_ram.sv
sv/all_pairs_shortest_path_core.sv
bench/testbench.sv
